### rtl/tshq_pkg.sv
// shared types, constants and the arithmetic program for the terrain strip height query
// depends on nothing; used by every module of the block but tshq_ram
package tshq_pkg;

    localparam int VERTEX_DEPTH_DEF = 4096;
    localparam int INDEX_DEPTH_DEF  = 8192;

    localparam int CW      = 24;  // coordinate width, signed Q15.8
    localparam int SLOT_W  = 13;
    localparam int REF_W   = 12;
    localparam int CNT_W   = 13;
    localparam int DEPTH_W = 17;  // holds any store depth up to 65536
    localparam int DIFF_W  = CW + 1;
    localparam int OPB_W   = 27;
    localparam int PROD_W  = DIFF_W + OPB_W;
    localparam int NRM_W   = 51;
    localparam int ACC_W   = 80;
    localparam int QW      = 27;
    localparam int HALF_SH = 26;  // split point of a normal component
    localparam int STEP_W  = 4;

    localparam logic [QW-1:0] QLIM = QW'(1) << 25;

    typedef enum logic [1:0] {
        CMD_WR_VTX = 2'd0,
        CMD_WR_IDX = 2'd1,
        CMD_FLOOR  = 2'd2,
        CMD_SNAP   = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        PK_ZERO, PK_X0, PK_X1, PK_X2, PK_XP,
        PK_Y0, PK_Y1, PK_Y2,
        PK_Z0, PK_Z1, PK_Z2, PK_ZP
    } t_pick;

    typedef enum logic [2:0] {
        BS_DIFF, BS_NXLO, BS_NXHI, BS_NZLO, BS_NZHI
    } t_bsrc;

    typedef enum logic [1:0] {
        ACC_LOAD, ACC_SUB, ACC_NEG
    } t_acc_op;

    typedef enum logic [2:0] {
        ACT_NONE, ACT_EDGE, ACT_NX, ACT_NY, ACT_NZ, ACT_DIV
    } t_act;

    typedef enum logic [1:0] {
        SL_NONE, SL_0, SL_1, SL_2
    } t_slot;

    typedef enum logic [1:0] {
        RES_NONE, RES_FLAT, RES_HGT
    } t_res;

    typedef enum logic [4:0] {
        ST_IDLE, ST_TRI, ST_IR0, ST_IR1, ST_IR2, ST_IR3, ST_VCHK,
        ST_VR0, ST_VR1, ST_VR2, ST_VR3, ST_OPS, ST_MUL, ST_ACC, ST_ACT,
        ST_DIV, ST_DONE
    } t_state;

    // one multiply-accumulate step: (a1 - a0) * b, b a difference or a normal half
    typedef struct packed {
        t_pick   a1;
        t_pick   a0;
        t_pick   b1;
        t_pick   b0;
        t_bsrc   bsrc;
        logic    shift;
        t_acc_op acc;
        t_act    act;
    } t_uop;

    typedef struct packed {
        logic       q_ld;
        logic       tri_inc;
        logic [1:0] idx_off;
        t_slot      ref_cap;
        t_slot      vtx_sel;
        t_slot      vtx_cap;
        logic       opnd_ld;
        logic       mul_en;
        logic       acc_en;
        t_uop       uop;
        logic       st_nx;
        logic       st_ny;
        logic       st_nz;
        logic       div_start;
        logic       out_ld;
        t_res       res_kind;
    } t_dp_cmd;

    typedef struct packed {
        logic tri_end;
        logic tri_bad;
        logic acc_neg;
        logic ny_zero;
        logic div_done;
        logic out_busy;
    } t_dp_sts;

    // winding is normalized at vertex fetch: odd triangles swap p1 and p2
    function automatic t_uop uop_rom(input logic [STEP_W-1:0] step);
        t_uop u;
        u = '{PK_ZERO, PK_ZERO, PK_ZERO, PK_ZERO, BS_DIFF, 1'b0, ACC_LOAD, ACT_NONE};
        case (step)
            4'd0:  u = '{PK_ZP, PK_Z0, PK_X2, PK_X0, BS_DIFF, 1'b0, ACC_LOAD, ACT_NONE};
            4'd1:  u = '{PK_XP, PK_X0, PK_Z2, PK_Z0, BS_DIFF, 1'b0, ACC_SUB,  ACT_EDGE};
            4'd2:  u = '{PK_ZP, PK_Z2, PK_X1, PK_X2, BS_DIFF, 1'b0, ACC_LOAD, ACT_NONE};
            4'd3:  u = '{PK_XP, PK_X2, PK_Z1, PK_Z2, BS_DIFF, 1'b0, ACC_SUB,  ACT_EDGE};
            4'd4:  u = '{PK_ZP, PK_Z1, PK_X0, PK_X1, BS_DIFF, 1'b0, ACC_LOAD, ACT_NONE};
            4'd5:  u = '{PK_XP, PK_X1, PK_Z0, PK_Z1, BS_DIFF, 1'b0, ACC_SUB,  ACT_EDGE};
            4'd6:  u = '{PK_Y1, PK_Y0, PK_Z2, PK_Z0, BS_DIFF, 1'b0, ACC_LOAD, ACT_NONE};
            4'd7:  u = '{PK_Z1, PK_Z0, PK_Y2, PK_Y0, BS_DIFF, 1'b0, ACC_SUB,  ACT_NX};
            4'd8:  u = '{PK_Z1, PK_Z0, PK_X2, PK_X0, BS_DIFF, 1'b0, ACC_LOAD, ACT_NONE};
            4'd9:  u = '{PK_X1, PK_X0, PK_Z2, PK_Z0, BS_DIFF, 1'b0, ACC_SUB,  ACT_NY};
            4'd10: u = '{PK_X1, PK_X0, PK_Y2, PK_Y0, BS_DIFF, 1'b0, ACC_LOAD, ACT_NONE};
            4'd11: u = '{PK_Y1, PK_Y0, PK_X2, PK_X0, BS_DIFF, 1'b0, ACC_SUB,  ACT_NZ};
            4'd12: u = '{PK_XP, PK_X0, PK_ZERO, PK_ZERO, BS_NXLO, 1'b0, ACC_NEG, ACT_NONE};
            4'd13: u = '{PK_XP, PK_X0, PK_ZERO, PK_ZERO, BS_NXHI, 1'b1, ACC_SUB, ACT_NONE};
            4'd14: u = '{PK_ZP, PK_Z0, PK_ZERO, PK_ZERO, BS_NZLO, 1'b0, ACC_SUB, ACT_NONE};
            4'd15: u = '{PK_ZP, PK_Z0, PK_ZERO, PK_ZERO, BS_NZHI, 1'b1, ACC_SUB, ACT_DIV};
            default: u = '{PK_ZERO, PK_ZERO, PK_ZERO, PK_ZERO, BS_DIFF, 1'b0, ACC_LOAD,
                           ACT_NONE};
        endcase
        return u;
    endfunction

endpackage

### rtl/terrain_strip_height_query.sv
// terrain strip height query, top level: stream and register ports, the stores
// depends on tshq_pkg, tshq_ram, tshq_ctrl, tshq_dp
//
// usage: the input stream carries write and query transactions, kind in s_tuser.
// a vertex or index write goes straight into its store and gives no result. a query
// walks strip triangles 0 .. triangle_count-1, stopping where a triangle's last index
// would pass the index store, and gives one result transaction with the adjusted
// height and the found / hit / flat-normal flags. each triangle is read and checked
// for degenerate or out-of-range references, a kept one is tested edge by edge, and
// the containing one runs the rest of the multiply-accumulate program and the divider,
// or no divide when its normal y is zero. each product passes the operand, multiply,
// accumulate and act steps of the shared multiplier; the divider gives one quotient
// bit per cycle.
// one query is worked at a time; s_tready is high only between transactions,
// but a new one is taken while the last result still waits in the output register.
// when m_tready is low the finished result holds and the next result waits.
// reset clears control state and triangle_count; the stores are undefined
// until written and need no clearing.
module terrain_strip_height_query
    import tshq_pkg::*;
#(
    parameter int VERTEX_DEPTH = VERTEX_DEPTH_DEF,
    parameter int INDEX_DEPTH  = INDEX_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // slot, coord_x, coord_y, coord_z, vertex_ref, zero pad
    input  logic [1:0]   s_tuser,   // cmd
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // result_y, found, hit, flat_normal_error, zero pad
    // register port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int VTX_AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
    localparam int IDX_AW = (INDEX_DEPTH > 1) ? $clog2(INDEX_DEPTH) : 1;
    localparam int REG_IDX_BIT = 2;   // word index of the register map
    localparam logic REG_TRI_COUNT = 1'b0;

    // input field positions inside s_tdata
    localparam int F_SLOT = 0;
    localparam int F_X    = F_SLOT + SLOT_W;
    localparam int F_Y    = F_X + CW;
    localparam int F_Z    = F_Y + CW;
    localparam int F_REF  = F_Z + CW;

    logic [CNT_W-1:0]     r_tri_count;
    t_cmd                 cmd;
    logic [SLOT_W-1:0]    slot;
    logic [DEPTH_W-1:0]   slot_ext;
    logic signed [CW-1:0] px, py, pz;
    logic [REF_W-1:0]     vref;
    logic                 s_acc, vtx_we, idx_we;
    t_dp_cmd              dpc;
    t_dp_sts              sts;
    logic [IDX_AW-1:0]    idx_raddr;
    logic [REF_W-1:0]     idx_rdata;
    logic [VTX_AW-1:0]    vtx_raddr;
    logic [3*CW-1:0]      vtx_rdata;
    logic signed [CW-1:0] result_y;
    logic                 found, hit, flat;
    logic                 cfg_wr;

    // register port, no wait states
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tri_count <= '0;
        end else if (cfg_wr && paddr[REG_IDX_BIT] == REG_TRI_COUNT) begin
            r_tri_count <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = (paddr[REG_IDX_BIT] == REG_TRI_COUNT) ? 32'(r_tri_count) : '0;

    // input field unpack
    assign cmd      = t_cmd'(s_tuser);
    assign slot     = s_tdata[F_SLOT +: SLOT_W];
    assign px       = s_tdata[F_X +: CW];
    assign py       = s_tdata[F_Y +: CW];
    assign pz       = s_tdata[F_Z +: CW];
    assign vref     = s_tdata[F_REF +: REF_W];
    assign slot_ext = DEPTH_W'(slot);

    // store writes go straight in; out-of-range slots are dropped
    assign s_acc  = s_tvalid && s_tready;
    assign vtx_we = s_acc && (cmd == CMD_WR_VTX) && (slot_ext < DEPTH_W'(VERTEX_DEPTH));
    assign idx_we = s_acc && (cmd == CMD_WR_IDX) && (slot_ext < DEPTH_W'(INDEX_DEPTH));

    tshq_ram #(
        .W     (3 * CW),
        .DEPTH (VERTEX_DEPTH)
    ) u_vtx_ram (
        .i_clk   (i_clk),
        .i_we    (vtx_we),
        .i_waddr (slot_ext[VTX_AW-1:0]),
        .i_wdata ({pz, py, px}),
        .i_raddr (vtx_raddr),
        .o_rdata (vtx_rdata)
    );

    tshq_ram #(
        .W     (REF_W),
        .DEPTH (INDEX_DEPTH)
    ) u_idx_ram (
        .i_clk   (i_clk),
        .i_we    (idx_we),
        .i_waddr (slot_ext[IDX_AW-1:0]),
        .i_wdata (vref),
        .i_raddr (idx_raddr),
        .o_rdata (idx_rdata)
    );

    tshq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_tvalid),
        .i_cmd     (cmd),
        .i_sts     (sts),
        .o_s_ready (s_tready),
        .o_dpc     (dpc)
    );

    tshq_dp #(
        .VERTEX_DEPTH (VERTEX_DEPTH),
        .INDEX_DEPTH  (INDEX_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dpc       (dpc),
        .o_sts       (sts),
        .i_tri_count (r_tri_count),
        .i_snap      (cmd == CMD_SNAP),
        .i_px        (px),
        .i_py        (py),
        .i_pz        (pz),
        .o_idx_raddr (idx_raddr),
        .i_idx_rdata (idx_rdata),
        .o_vtx_raddr (vtx_raddr),
        .i_vtx_rdata (vtx_rdata),
        .i_m_tready  (m_tready),
        .o_m_tvalid  (m_tvalid),
        .o_result_y  (result_y),
        .o_found     (found),
        .o_hit       (hit),
        .o_flat      (flat)
    );

    assign m_tdata = {5'b0, flat, hit, found, result_y};

    // a result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dpc.out_ld |-> !sts.out_busy)
        else $error("result register overwritten");

    // the divider is never started on a flat normal
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dpc.div_start |-> !sts.ny_zero)
        else $error("divide by zero normal");

    // an accepted query keeps the input closed while it is walked
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (cmd == CMD_FLOOR || cmd == CMD_SNAP)) |=> !s_tready)
        else $error("input open during query");

    // the divider only finishes inside a query
    a_div_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.div_done |-> !s_tready)
        else $error("divider finished while idle");

endmodule

### rtl/tshq_ram.sv
// generic simple dual-port ram with registered read data
// depends on nothing
module tshq_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/tshq_div.sv
// restoring divider, one quotient bit per cycle, quotient clamped to +-2^25
// depends on tshq_pkg
module tshq_div
    import tshq_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [ACC_W-1:0] i_num,
    input  logic signed [NRM_W-1:0] i_den,
    output logic                    o_done,
    output logic signed [QW-1:0]    o_quot
);

    localparam int CNT_BITS = $clog2(ACC_W + 1);

    logic                r_busy, r_fin, r_done, r_ovf, r_neg;
    logic [CNT_BITS-1:0] r_cnt;
    logic [ACC_W-1:0]    r_n;
    logic [NRM_W-1:0]    r_rem, r_den;
    logic [QW-1:0]       r_q;
    logic signed [QW-1:0] r_quot;

    logic [NRM_W:0]   rem2, diff;
    logic             ge;
    logic [QW-1:0]    mag;

    assign rem2 = {r_rem, r_n[ACC_W-1]};
    assign diff = rem2 - {1'b0, r_den};
    assign ge   = rem2 >= {1'b0, r_den};
    assign mag  = (r_ovf || r_q > QLIM) ? QLIM : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(ACC_W);
                r_n    <= i_num[ACC_W-1] ? -i_num : i_num;
                r_den  <= i_den[NRM_W-1] ? -i_den : i_den;
                r_neg  <= i_num[ACC_W-1] ^ i_den[NRM_W-1];
                r_rem  <= '0;
                r_q    <= '0;
                r_ovf  <= 1'b0;
            end else if (r_busy) begin
                r_rem <= ge ? diff[NRM_W-1:0] : rem2[NRM_W-1:0];
                r_n   <= r_n << 1;
                r_q   <= {r_q[QW-2:0], ge};
                r_ovf <= r_ovf | r_q[QW-1];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_quot <= r_neg ? -$signed(mag) : $signed(mag);
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

### rtl/tshq_dp.sv
// datapath: query point, strip and vertex registers, shared multiplier, accumulator,
// normal registers, divider and result register; depends on tshq_pkg and tshq_div
module tshq_dp
    import tshq_pkg::*;
#(
    parameter int VERTEX_DEPTH = VERTEX_DEPTH_DEF,
    parameter int INDEX_DEPTH  = INDEX_DEPTH_DEF,
    parameter int VTX_AW       = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1,
    parameter int IDX_AW       = (INDEX_DEPTH > 1) ? $clog2(INDEX_DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_dpc,
    output t_dp_sts              o_sts,
    input  logic [CNT_W-1:0]     i_tri_count,
    input  logic                 i_snap,
    input  logic signed [CW-1:0] i_px,
    input  logic signed [CW-1:0] i_py,
    input  logic signed [CW-1:0] i_pz,
    output logic [IDX_AW-1:0]    o_idx_raddr,
    input  logic [REF_W-1:0]     i_idx_rdata,
    output logic [VTX_AW-1:0]    o_vtx_raddr,
    input  logic [3*CW-1:0]      i_vtx_rdata,
    input  logic                 i_m_tready,
    output logic                 o_m_tvalid,
    output logic signed [CW-1:0] o_result_y,
    output logic                 o_found,
    output logic                 o_hit,
    output logic                 o_flat
);

    localparam logic signed [QW:0] H_MAX = (QW+1)'(8388607);
    localparam logic signed [QW:0] H_MIN = -(QW+1)'(8388608);

    logic signed [CW-1:0]     r_px, r_py, r_pz;
    logic                     r_snap;
    logic [CNT_W-1:0]         r_tri;
    logic [REF_W-1:0]         r_ref [3];
    logic signed [CW-1:0]     r_vx [3];
    logic signed [CW-1:0]     r_vy [3];
    logic signed [CW-1:0]     r_vz [3];
    logic signed [DIFF_W-1:0] r_opa;
    logic signed [OPB_W-1:0]  r_opb;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [NRM_W-1:0]  r_nx, r_ny, r_nz;
    logic                     r_out_valid, r_out_found, r_out_hit, r_out_flat;
    logic signed [CW-1:0]     r_out_y;

    logic [DEPTH_W-1:0]       tri_ext, idx_addr, ref_sel;
    logic signed [CW-1:0]     pa1, pa0, pb1, pb0;
    logic signed [DIFF_W-1:0] opa, bdiff;
    logic signed [OPB_W-1:0]  opb;
    logic signed [ACC_W-1:0]  prod_ext, prod_sh;
    logic                     div_done;
    logic signed [QW-1:0]     quot;
    logic signed [QW:0]       hsum;
    logic signed [CW-1:0]     hsat;
    logic                     hhit;
    logic                     odd;

    function automatic logic signed [CW-1:0] pick(input t_pick p);
        logic signed [CW-1:0] v;
        v = '0;
        case (p)
            PK_X0:   v = r_vx[0];
            PK_X1:   v = r_vx[1];
            PK_X2:   v = r_vx[2];
            PK_XP:   v = r_px;
            PK_Y0:   v = r_vy[0];
            PK_Y1:   v = r_vy[1];
            PK_Y2:   v = r_vy[2];
            PK_Z0:   v = r_vz[0];
            PK_Z1:   v = r_vz[1];
            PK_Z2:   v = r_vz[2];
            PK_ZP:   v = r_pz;
            default: v = '0;
        endcase
        return v;
    endfunction

    // strip walk addressing
    assign odd      = r_tri[0];
    assign tri_ext  = DEPTH_W'(r_tri);
    assign idx_addr = tri_ext + DEPTH_W'(i_dpc.idx_off);
    assign o_idx_raddr = idx_addr[IDX_AW-1:0];

    always_comb begin
        case (i_dpc.vtx_sel)
            SL_1:    ref_sel = DEPTH_W'(odd ? r_ref[2] : r_ref[1]);
            SL_2:    ref_sel = DEPTH_W'(odd ? r_ref[1] : r_ref[2]);
            default: ref_sel = DEPTH_W'(r_ref[0]);
        endcase
    end
    assign o_vtx_raddr = ref_sel[VTX_AW-1:0];

    // operand selection
    assign pa1   = pick(i_dpc.uop.a1);
    assign pa0   = pick(i_dpc.uop.a0);
    assign pb1   = pick(i_dpc.uop.b1);
    assign pb0   = pick(i_dpc.uop.b0);
    assign opa   = {pa1[CW-1], pa1} - {pa0[CW-1], pa0};
    assign bdiff = {pb1[CW-1], pb1} - {pb0[CW-1], pb0};

    always_comb begin
        case (i_dpc.uop.bsrc)
            BS_NXLO: opb = {1'b0, r_nx[HALF_SH-1:0]};
            BS_NXHI: opb = {{(OPB_W-NRM_W+HALF_SH){r_nx[NRM_W-1]}}, r_nx[NRM_W-1:HALF_SH]};
            BS_NZLO: opb = {1'b0, r_nz[HALF_SH-1:0]};
            BS_NZHI: opb = {{(OPB_W-NRM_W+HALF_SH){r_nz[NRM_W-1]}}, r_nz[NRM_W-1:HALF_SH]};
            default: opb = {{(OPB_W-DIFF_W){bdiff[DIFF_W-1]}}, bdiff};
        endcase
    end

    assign prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign prod_sh  = i_dpc.uop.shift ? (prod_ext <<< HALF_SH) : prod_ext;

    // plane height from the quotient, saturated to Q15.8
    assign hsum = {quot[QW-1], quot} + {{(QW+1-CW){r_vy[0][CW-1]}}, r_vy[0]};
    always_comb begin
        if (hsum > H_MAX) begin
            hsat = CW'(H_MAX);
        end else if (hsum < H_MIN) begin
            hsat = CW'(H_MIN);
        end else begin
            hsat = hsum[CW-1:0];
        end
    end
    assign hhit = r_snap || (hsat >= r_py);

    always_ff @(posedge i_clk) begin
        if (i_dpc.q_ld) begin
            r_px   <= i_px;
            r_py   <= i_py;
            r_pz   <= i_pz;
            r_snap <= i_snap;
            r_tri  <= '0;
        end else if (i_dpc.tri_inc) begin
            r_tri <= r_tri + 1'b1;
        end
        case (i_dpc.ref_cap)
            SL_0:    r_ref[0] <= i_idx_rdata;
            SL_1:    r_ref[1] <= i_idx_rdata;
            SL_2:    r_ref[2] <= i_idx_rdata;
            default: ;
        endcase
        case (i_dpc.vtx_cap)
            SL_0: begin
                r_vx[0] <= i_vtx_rdata[CW-1:0];
                r_vy[0] <= i_vtx_rdata[2*CW-1:CW];
                r_vz[0] <= i_vtx_rdata[3*CW-1:2*CW];
            end
            SL_1: begin
                r_vx[1] <= i_vtx_rdata[CW-1:0];
                r_vy[1] <= i_vtx_rdata[2*CW-1:CW];
                r_vz[1] <= i_vtx_rdata[3*CW-1:2*CW];
            end
            SL_2: begin
                r_vx[2] <= i_vtx_rdata[CW-1:0];
                r_vy[2] <= i_vtx_rdata[2*CW-1:CW];
                r_vz[2] <= i_vtx_rdata[3*CW-1:2*CW];
            end
            default: ;
        endcase
        if (i_dpc.opnd_ld) begin
            r_opa <= opa;
            r_opb <= opb;
        end
        if (i_dpc.mul_en) begin
            r_prod <= r_opa * r_opb;
        end
        if (i_dpc.acc_en) begin
            case (i_dpc.uop.acc)
                ACC_SUB: r_acc <= r_acc - prod_sh;
                ACC_NEG: r_acc <= -prod_sh;
                default: r_acc <= prod_sh;
            endcase
        end
        if (i_dpc.st_nx) r_nx <= r_acc[NRM_W-1:0];
        if (i_dpc.st_ny) r_ny <= r_acc[NRM_W-1:0];
        if (i_dpc.st_nz) r_nz <= r_acc[NRM_W-1:0];
        if (i_dpc.out_ld) begin
            case (i_dpc.res_kind)
                RES_FLAT: begin
                    r_out_y     <= r_py;
                    r_out_found <= 1'b1;
                    r_out_hit   <= 1'b0;
                    r_out_flat  <= 1'b1;
                end
                RES_HGT: begin
                    r_out_y     <= hhit ? hsat : r_py;
                    r_out_found <= 1'b1;
                    r_out_hit   <= hhit;
                    r_out_flat  <= 1'b0;
                end
                default: begin
                    r_out_y     <= r_py;
                    r_out_found <= 1'b0;
                    r_out_hit   <= 1'b0;
                    r_out_flat  <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_dpc.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    tshq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_dpc.div_start),
        .i_num   (r_acc),
        .i_den   (r_ny),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    assign o_sts.tri_end  = (tri_ext >= DEPTH_W'(i_tri_count)) ||
                            (tri_ext + DEPTH_W'(2) >= DEPTH_W'(INDEX_DEPTH));
    assign o_sts.tri_bad  = (r_ref[0] == r_ref[1]) || (r_ref[1] == r_ref[2]) ||
                            (DEPTH_W'(r_ref[0]) >= DEPTH_W'(VERTEX_DEPTH)) ||
                            (DEPTH_W'(r_ref[1]) >= DEPTH_W'(VERTEX_DEPTH)) ||
                            (DEPTH_W'(r_ref[2]) >= DEPTH_W'(VERTEX_DEPTH));
    assign o_sts.acc_neg  = r_acc[ACC_W-1];
    assign o_sts.ny_zero  = (r_ny == '0);
    assign o_sts.div_done = div_done;
    assign o_sts.out_busy = r_out_valid && !i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_result_y = r_out_y;
    assign o_found    = r_out_found;
    assign o_hit      = r_out_hit;
    assign o_flat     = r_out_flat;

endmodule

### rtl/tshq_ctrl.sv
// controller: walks the strip, sequences fetches, the multiply-accumulate program and
// the divider; depends on tshq_pkg
module tshq_ctrl
    import tshq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_valid,
    input  t_cmd    i_cmd,
    input  t_dp_sts i_sts,
    output logic    o_s_ready,
    output t_dp_cmd o_dpc
);

    t_state             r_state, n_state;
    logic [STEP_W-1:0]  r_step, n_step;
    t_res               r_kind, n_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_kind  <= RES_NONE;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_kind  <= n_kind;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_kind  = r_kind;
        o_dpc   = '0;
        o_dpc.uop      = uop_rom(r_step);
        o_dpc.res_kind = r_kind;
        o_s_ready = (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_s_valid && (i_cmd inside {CMD_FLOOR, CMD_SNAP})) begin
                    o_dpc.q_ld = 1'b1;
                    n_state = ST_TRI;
                end
            end
            ST_TRI: begin
                if (i_sts.tri_end) begin
                    n_kind  = RES_NONE;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_IR0;
                end
            end
            ST_IR0: begin
                o_dpc.idx_off = 2'd0;
                n_state = ST_IR1;
            end
            ST_IR1: begin
                o_dpc.idx_off = 2'd1;
                o_dpc.ref_cap = SL_0;
                n_state = ST_IR2;
            end
            ST_IR2: begin
                o_dpc.idx_off = 2'd2;
                o_dpc.ref_cap = SL_1;
                n_state = ST_IR3;
            end
            ST_IR3: begin
                o_dpc.ref_cap = SL_2;
                n_state = ST_VCHK;
            end
            ST_VCHK: begin
                if (i_sts.tri_bad) begin
                    o_dpc.tri_inc = 1'b1;
                    n_state = ST_TRI;
                end else begin
                    n_state = ST_VR0;
                end
            end
            ST_VR0: begin
                o_dpc.vtx_sel = SL_0;
                n_state = ST_VR1;
            end
            ST_VR1: begin
                o_dpc.vtx_sel = SL_1;
                o_dpc.vtx_cap = SL_0;
                n_state = ST_VR2;
            end
            ST_VR2: begin
                o_dpc.vtx_sel = SL_2;
                o_dpc.vtx_cap = SL_1;
                n_state = ST_VR3;
            end
            ST_VR3: begin
                o_dpc.vtx_cap = SL_2;
                n_step  = '0;
                n_state = ST_OPS;
            end
            ST_OPS: begin
                o_dpc.opnd_ld = 1'b1;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                o_dpc.mul_en = 1'b1;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                o_dpc.acc_en = 1'b1;
                n_state = ST_ACT;
            end
            ST_ACT: begin
                n_step  = r_step + 1'b1;
                n_state = ST_OPS;
                case (o_dpc.uop.act)
                    ACT_EDGE: begin
                        if (i_sts.acc_neg) begin
                            o_dpc.tri_inc = 1'b1;
                            n_state = ST_TRI;
                        end
                    end
                    ACT_NX: o_dpc.st_nx = 1'b1;
                    ACT_NY: o_dpc.st_ny = 1'b1;
                    ACT_NZ: begin
                        o_dpc.st_nz = 1'b1;
                        if (i_sts.ny_zero) begin
                            n_kind  = RES_FLAT;
                            n_state = ST_DONE;
                        end
                    end
                    ACT_DIV: begin
                        o_dpc.div_start = 1'b1;
                        n_state = ST_DIV;
                    end
                    default: ;
                endcase
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_kind  = RES_HGT;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!i_sts.out_busy) begin
                    o_dpc.out_ld = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for terrain_strip_height_query: stream writes and queries,
// register writes over the apb port; depends on tshq_pkg and the block's rtl
module testbench;
    import tshq_pkg::*;

    typedef logic signed [127:0] t_wide;

    // one height answer as the block should return it
    typedef struct {
        logic signed [23:0] y;
        bit found;
        bit hit;
        bit flat;
    } t_height_answer;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;   // slot, coord_x, coord_y, coord_z, vertex_ref, zero pad
    logic [1:0]   s_tuser;   // cmd
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;   // result_y, found, hit, flat_normal_error, zero pad
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    localparam int VTX_N = 4096;
    localparam int IDX_N = 8192;
    localparam logic [2:0] ADDR_TRI_COUNT = 3'd0;
    localparam int STALL_LIMIT = 5000;

    // mirror of the block's stores and register
    longint vtx_x [VTX_N];
    longint vtx_y [VTX_N];
    longint vtx_z [VTX_N];
    int     strip_ref [IDX_N];
    int     tri_count;

    t_height_answer pending_heights[$];
    int errors, n_queries, n_found, n_hits, n_flat;
    int tx_idle, rx_idle, stall_cycles;

    // vertex numbers that the random part may reference, all written up front
    int ref_pool[16] = '{0, 1, 2, 3, 4, 5, 6, 7,
                         4088, 4089, 4090, 4091, 4092, 4093, 4094, 4095};

    terrain_strip_height_query uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit edge_inside(longint ax, longint az, longint bx, longint bz,
                                       longint px, longint pz);
        return (pz - az) * (bx - ax) - (px - ax) * (bz - az) >= 0;
    endfunction

    function automatic longint clip24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    // walk the strip and find the surface height under the query point
    function automatic t_height_answer strip_height(t_cmd kind, longint px, longint py,
                                                    longint pz);
        t_height_answer r;
        int r0, r1, r2;
        longint x0, y0, z0, x1, y1, z1, x2, y2, z2;
        longint ax, ay, az, bx, by, bz, nx, ny, nz, h;
        bit in_tri;
        t_wide num, q;
        r.y = py[23:0];
        r.found = 0;
        r.hit = 0;
        r.flat = 0;
        for (int i = 0; i < tri_count; i++) begin
            if (i + 2 >= IDX_N) break;
            r0 = strip_ref[i];
            r1 = strip_ref[i + 1];
            r2 = strip_ref[i + 2];
            if (r0 == r1 || r1 == r2) continue;
            if (r0 >= VTX_N || r1 >= VTX_N || r2 >= VTX_N) continue;
            x0 = vtx_x[r0]; y0 = vtx_y[r0]; z0 = vtx_z[r0];
            x1 = vtx_x[r1]; y1 = vtx_y[r1]; z1 = vtx_z[r1];
            x2 = vtx_x[r2]; y2 = vtx_y[r2]; z2 = vtx_z[r2];
            // even triangles wind p0-p2-p1, odd ones p0-p1-p2
            if (i % 2 == 0)
                in_tri = edge_inside(x0, z0, x2, z2, px, pz) &&
                         edge_inside(x2, z2, x1, z1, px, pz) &&
                         edge_inside(x1, z1, x0, z0, px, pz);
            else
                in_tri = edge_inside(x0, z0, x1, z1, px, pz) &&
                         edge_inside(x1, z1, x2, z2, px, pz) &&
                         edge_inside(x2, z2, x0, z0, px, pz);
            if (!in_tri) continue;
            if (i % 2 == 0) begin
                ax = x1 - x0; ay = y1 - y0; az = z1 - z0;
                bx = x2 - x0; by = y2 - y0; bz = z2 - z0;
            end else begin
                ax = x2 - x0; ay = y2 - y0; az = z2 - z0;
                bx = x1 - x0; by = y1 - y0; bz = z1 - z0;
            end
            nx = ay * bz - az * by;
            ny = az * bx - ax * bz;
            nz = ax * by - ay * bx;
            r.found = 1;
            if (ny == 0) begin
                r.flat = 1;
            end else begin
                num = -(t_wide'(px - x0) * t_wide'(nx) + t_wide'(pz - z0) * t_wide'(nz));
                q = num / t_wide'(ny);
                if (q > t_wide'(33554432)) q = t_wide'(33554432);
                if (q < -t_wide'(33554432)) q = -t_wide'(33554432);
                h = clip24(longint'(q) + y0);
                if (kind == CMD_SNAP || h >= py) begin
                    r.y = h[23:0];
                    r.hit = 1;
                end
            end
            break;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    // one input transaction; the mirror is updated once the block takes it
    task automatic send_item(t_cmd kind, int slot, longint x, longint y, longint z,
                             int vref);
        t_height_answer a;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, vref[11:0], z[23:0], y[23:0], x[23:0], slot[12:0]};
        do @(posedge i_clk); while (!s_tready);
        case (kind)
            CMD_WR_VTX: begin
                if (slot < VTX_N) begin
                    vtx_x[slot] = x;
                    vtx_y[slot] = y;
                    vtx_z[slot] = z;
                end
            end
            CMD_WR_IDX: strip_ref[slot] = vref;
            default: begin
                a = strip_height(kind, x, y, z);
                pending_heights = {pending_heights, a};
                n_queries++;
                n_found += a.found;
                n_hits += a.hit;
                n_flat += a.flat;
            end
        endcase
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
    endtask

    // wait for all answers, then let the block settle before touching the register
    task automatic drain();
        stop_sending();
        while (pending_heights.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_triangle_count(int n);
        drain();
        @(negedge i_clk);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= ADDR_TRI_COUNT;
        pwdata <= 32'(n);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tri_count = n;
    endtask

    task automatic query_near(t_cmd kind, int a, int b, int c, longint y);
        longint x, z;
        x = clip24((vtx_x[a] + vtx_x[b] + vtx_x[c]) / 3 + longint'($urandom_range(128)) - 64);
        z = clip24((vtx_z[a] + vtx_z[b] + vtx_z[c]) / 3 + longint'($urandom_range(128)) - 64);
        send_item(kind, 0, x, y, z, 0);
    endtask

    function automatic longint rand_coord();
        if ($urandom_range(3) == 0)
            return longint'($signed(24'($urandom)));
        return longint'($urandom_range(8192)) - 4096;
    endfunction

    // no triangles walked: y passes through, nothing found
    task automatic test_empty_strip();
        set_triangle_count(0);
        send_item(CMD_FLOOR, 0, -8388608, 8388607, 0, 0);
        send_item(CMD_SNAP, 8191, 8388607, -8388608, -1, 4095);
    endtask

    // a two-triangle quad: floor above and below, snap, outside, on a corner
    task automatic test_quad();
        send_item(CMD_WR_VTX, 0, 0, 0, 0, 0);
        send_item(CMD_WR_VTX, 1, 0, 256, 1024, 0);
        send_item(CMD_WR_VTX, 2, 1024, 512, 0, 0);
        send_item(CMD_WR_VTX, 3, 1024, 1024, 1024, 0);
        for (int s = 0; s < 4; s++) send_item(CMD_WR_IDX, s, 0, 0, 0, s);
        set_triangle_count(2);
        send_item(CMD_FLOOR, 0, 341, -8388608, 341, 0);
        send_item(CMD_FLOOR, 0, 341, 8388607, 341, 0);
        send_item(CMD_SNAP, 0, 683, 8388607, 683, 0);
        send_item(CMD_SNAP, 0, -1000, 77, 5000, 0);
        send_item(CMD_FLOOR, 0, 0, -5, 0, 0);
    endtask

    // collinear vertices give a zero normal y; repeated refs and a dropped write
    task automatic test_flat_and_degenerate();
        send_item(CMD_WR_VTX, 4, 4096, 100, 4096, 0);
        send_item(CMD_WR_VTX, 5, 5120, 300, 5120, 0);
        send_item(CMD_WR_VTX, 6, 6144, 900, 6144, 0);
        send_item(CMD_WR_VTX, 8191, 1, 2, 3, 0);  // beyond the vertex store, dropped
        for (int s = 4; s < 7; s++) send_item(CMD_WR_IDX, s, 0, 0, 0, s);
        send_item(CMD_WR_IDX, 7, 0, 0, 0, 6);
        set_triangle_count(6);
        send_item(CMD_SNAP, 0, 5120, 50, 5120, 0);
        send_item(CMD_FLOOR, 0, 5632, -50, 5632, 0);
    endtask

    // vertices and strip entries that the random runs start from
    task automatic load_random_terrain();
        for (int k = 0; k < 16; k++)
            send_item(CMD_WR_VTX, ref_pool[k], rand_coord(), rand_coord(), rand_coord(), 0);
        for (int s = 0; s < 16; s++)
            send_item(CMD_WR_IDX, s, 0, 0, 0, ref_pool[$urandom_range(15)]);
    endtask

    // random terrain updates mixed with queries aimed at strip triangles
    task automatic test_random_terrain(int n_items, int tri_n);
        int t, pick;
        set_triangle_count(tri_n);
        for (int k = 0; k < n_items; k++) begin
            pick = $urandom_range(99);
            t = $urandom_range(tri_n - 1);
            if (pick < 55)
                query_near(t_cmd'($urandom_range(2, 3)), strip_ref[t], strip_ref[t + 1],
                           strip_ref[t + 2], rand_coord());
            else if (pick < 65)
                send_item(t_cmd'($urandom_range(2, 3)), $urandom_range(8191),
                          rand_coord(), rand_coord(), rand_coord(), $urandom_range(4095));
            else if (pick < 80)
                send_item(CMD_WR_VTX, ref_pool[$urandom_range(15)], rand_coord(),
                          rand_coord(), rand_coord(), $urandom_range(4095));
            else if (pick < 85)
                send_item(CMD_WR_VTX, $urandom_range(4096, 8191), rand_coord(),
                          rand_coord(), rand_coord(), 0);
            else if (pick < 95)
                send_item(CMD_WR_IDX, $urandom_range(15), rand_coord(), rand_coord(),
                          rand_coord(), ref_pool[$urandom_range(15)]);
            else
                send_item(CMD_WR_IDX, $urandom_range(8191), rand_coord(), rand_coord(),
                          rand_coord(), ref_pool[$urandom_range(15)]);
        end
    endtask

    // longer walk: a run of degenerate triangles before the last two real ones
    task automatic test_long_strip();
        for (int s = 0; s < 10; s++) send_item(CMD_WR_IDX, s, 0, 0, 0, 0);
        send_item(CMD_WR_IDX, 10, 0, 0, 0, 1);
        send_item(CMD_WR_IDX, 11, 0, 0, 0, 2);
        send_item(CMD_WR_IDX, 12, 0, 0, 0, 3);
        set_triangle_count(11);
        query_near(CMD_SNAP, 1, 2, 3, 0);
        query_near(CMD_FLOOR, 1, 2, 3, -8388608);
    endtask

    // answer checker, sampled at the rising edge
    always @(posedge i_clk) begin
        t_height_answer w;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_heights.size() == 0) begin
                report_mismatch("unexpected result transaction", 1, 0);
            end else begin
                w = pending_heights.pop_front();
                if (m_tdata[23:0] !== w.y)
                    report_mismatch("result_y", $signed(m_tdata[23:0]), w.y);
                if (m_tdata[24] !== w.found) report_mismatch("found", m_tdata[24], w.found);
                if (m_tdata[25] !== w.hit) report_mismatch("hit", m_tdata[25], w.hit);
                if (m_tdata[26] !== w.flat)
                    report_mismatch("flat_normal_error", m_tdata[26], w.flat);
            end
        end
    end

    // receiver back-pressure
    always @(negedge i_clk)
        m_tready <= ($urandom_range(99) >= rx_idle);

    // watchdog on cycles with no transaction anywhere
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        errors = 0; n_queries = 0; n_found = 0; n_hits = 0; n_flat = 0;
        stall_cycles = 0;
        tx_idle = 0;
        rx_idle = 0;
        tri_count = 0;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_WR_VTX;
        m_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        tx_idle = 30; rx_idle = 78;
        test_empty_strip();
        test_quad();
        test_flat_and_degenerate();
        load_random_terrain();
        test_random_terrain(12, 14);
        tx_idle = 78; rx_idle = 30;
        test_random_terrain(12, 9);
        tx_idle = 0; rx_idle = 0;
        test_random_terrain(12, 1);
        test_long_strip();
        drain();
        repeat (100) @(posedge i_clk);

        $display("covered %0d queries: %0d inside a triangle, %0d heights taken, %0d flat",
                 n_queries, n_found, n_hits, n_flat);
        $display("triangle counts from 0 up to 14, with and without stalls on both sides");
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
